// File: sv/counting_semaphore_waiter_table_core_defines.svh
// assertion macros for the semaphore core
`ifndef COUNTING_SEMAPHORE_WAITER_TABLE_CORE_DEFINES_SVH
`define COUNTING_SEMAPHORE_WAITER_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CSWT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define CSWT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/cswt_pkg.sv
`timescale 1ns / 1ps
package cswt_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned IdW     = 8;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned StatusW = 3;

  // request codes
  localparam logic [ReqW-1:0] REQ_TRY  = 2'd0;
  localparam logic [ReqW-1:0] REQ_WAIT = 2'd1;
  localparam logic [ReqW-1:0] REQ_INC  = 2'd2;
  localparam logic [ReqW-1:0] REQ_RSVD = 2'd3;

  // result status codes
  localparam logic [StatusW-1:0] ST_GRANTED     = 3'd0;
  localparam logic [StatusW-1:0] ST_WOULD_BLOCK = 3'd1;
  localparam logic [StatusW-1:0] ST_QUEUED      = 3'd2;
  localparam logic [StatusW-1:0] ST_FULL        = 3'd3;
  localparam logic [StatusW-1:0] ST_WAKE        = 3'd4;

  typedef struct packed {
    logic load_req;   // latch request fields
    logic exec_take;  // resolve a try or wait and emit its result
    logic inc_count;  // saturating increment
    logic emit_ack;   // increment with nobody queued
    logic read_slot;  // fetch lowest queued waiter, free its slot
    logic emit_wake;  // emit the fetched waiter
  } cswt_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic occ_any;    // at least one waiter queued
    logic wake_last;  // fetched waiter was the final one
  } cswt_sts_t;

endpackage

// File: sv/cswt_ctrl.sv
`timescale 1ns / 1ps
module cswt_ctrl
  import cswt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [ReqW-1:0] in_req_i,
  output logic            in_ready_o,
  input  cswt_sts_t       sts_i,
  output cswt_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_INC,
    S_ACK,
    S_READ,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_req_i)
            REQ_TRY, REQ_WAIT: begin
              cmd_o.load_req = 1'b1;
              state_d        = S_TAKE;
            end
            REQ_INC: begin
              cmd_o.load_req = 1'b1;
              state_d        = S_INC;
            end
            REQ_RSVD: state_d = S_IDLE;  // dropped, no result
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_TAKE: begin
        if (sts_i.out_free) begin
          cmd_o.exec_take = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_INC: begin
        cmd_o.inc_count = 1'b1;
        state_d         = sts_i.occ_any ? S_READ : S_ACK;
      end
      S_ACK: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ack = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.read_slot = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_wake = 1'b1;
          state_d         = sts_i.wake_last ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/cswt_dp.sv
`timescale 1ns / 1ps
module cswt_dp
  import cswt_pkg::*;
#(
  parameter int unsigned WAIT_SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CountW-1:0]  cfg_wdata_i,
  input  logic [ReqW-1:0]    in_req_i,
  input  logic [IdW-1:0]     in_id_i,
  input  cswt_cmd_t          cmd_i,
  output cswt_sts_t          sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [StatusW-1:0] out_status_o,
  output logic [IdW-1:0]     out_woken_o,
  output logic               out_last_o
);

  localparam int unsigned SlotW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;

  logic [CountW-1:0]     count_q, count_d;
  logic [WAIT_SLOTS-1:0] occ_q, occ_d;
  logic [IdW-1:0]        slot_mem [WAIT_SLOTS];
  logic [ReqW-1:0]       req_q;
  logic [IdW-1:0]        id_q;
  logic [IdW-1:0]        rd_id_q;
  logic                  wake_last_q;
  logic                  out_valid_q, out_valid_d;
  logic [StatusW-1:0]    out_status_q;
  logic [IdW-1:0]        out_woken_q;
  logic                  out_last_q;

  logic [WAIT_SLOTS-1:0] empty_oh, occ_oh;
  logic [SlotW-1:0]      empty_idx, occ_idx;
  logic                  has_empty;
  logic                  do_queue;
  logic                  emit;
  logic [StatusW-1:0]    take_status;

  // lowest clear and lowest set bit, isolated by carry
  assign empty_oh  = ~occ_q & (occ_q + WAIT_SLOTS'(1));
  assign occ_oh    = occ_q & (~occ_q + WAIT_SLOTS'(1));
  assign has_empty = |empty_oh;

  always_comb begin
    empty_idx = '0;
    occ_idx   = '0;
    for (int i = 0; i < WAIT_SLOTS; i++) begin
      if (empty_oh[i]) empty_idx = empty_idx | SlotW'(i);
      if (occ_oh[i])   occ_idx   = occ_idx | SlotW'(i);
    end
  end

  always_comb begin
    do_queue    = 1'b0;
    take_status = ST_FULL;
    if (count_q != '0) begin
      take_status = ST_GRANTED;
    end else if (req_q == REQ_TRY) begin
      take_status = ST_WOULD_BLOCK;
    end else if (id_q != '0 && has_empty) begin
      take_status = ST_QUEUED;
      do_queue    = 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cfg_we_i) begin
      count_d = cfg_wdata_i;
    end else if (cmd_i.exec_take && count_q != '0) begin
      count_d = count_q - CountW'(1);
    end else if (cmd_i.inc_count && count_q != '1) begin
      count_d = count_q + CountW'(1);
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (cmd_i.exec_take && do_queue) occ_d[empty_idx] = 1'b1;
    if (cmd_i.read_slot)             occ_d[occ_idx]   = 1'b0;
  end

  assign emit = cmd_i.exec_take | cmd_i.emit_ack | cmd_i.emit_wake;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_take && do_queue) begin
      slot_mem[empty_idx] <= id_q;
    end
    if (cmd_i.read_slot) begin
      rd_id_q     <= slot_mem[occ_idx];
      wake_last_q <= ((occ_q & ~occ_oh) == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
      id_q  <= in_id_i;
    end
    if (cmd_i.exec_take) begin
      out_status_q <= take_status;
      out_woken_q  <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_ack) begin
      out_status_q <= ST_WAKE;
      out_woken_q  <= '0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_wake) begin
      out_status_q <= ST_WAKE;
      out_woken_q  <= rd_id_q;
      out_last_q   <= wake_last_q;
    end
  end

  assign sts_o.out_free  = ~out_valid_q | out_ready_i;
  assign sts_o.occ_any   = |occ_q;
  assign sts_o.wake_last = wake_last_q;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_woken_o  = out_woken_q;
  assign out_last_o   = out_last_q;

endmodule

// File: sv/counting_semaphore_waiter_table_core.sv
`timescale 1ns / 1ps
// Counting semaphore with a table of WAIT_SLOTS waiting requesters. Requests
// enter on the s_axis side (kind in tuser, requester id in tdata) and results
// leave on m_axis (status in tuser, woken id in tdata, tlast on the final
// result of a request). One request is handled at a time. A try or wait is
// latched on acceptance and then resolved into the output register. An
// increment with nobody queued raises the count and then emits an
// acknowledgement; with waiters queued each waiter is fetched through the
// single read port of the slot memory and then pushed out, lowest slot first.
// A request kind of 3 is dropped with no result. Backpressure on m_axis stalls
// each result step. Writing the configuration port loads the count directly;
// the slot table is empty after reset with no clearing pass.
module counting_semaphore_waiter_table_core
  import cswt_pkg::*;
#(
  parameter int unsigned WAIT_SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] requester_id
  input  logic [1:0]        s_axis_tuser,   // [1:0] req_type
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] woken_id
  output logic [2:0]        m_axis_tuser,   // [2:0] status
  output logic              m_axis_tlast
);

`include "counting_semaphore_waiter_table_core_defines.svh"

  cswt_cmd_t cmd;
  cswt_sts_t sts;

  cswt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_req_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cswt_dp #(
    .WAIT_SLOTS (WAIT_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_req_i     (s_axis_tuser),
    .in_id_i      (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_woken_o  (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  `CSWT_ASSERT_NOW(a_emit_has_room, clk_i, rst_ni, cmd.exec_take || cmd.emit_ack || cmd.emit_wake, sts.out_free, "result pushed into a full output register")
  `CSWT_ASSERT_NOW(a_read_needs_waiter, clk_i, rst_ni, cmd.read_slot, sts.occ_any, "slot fetch with no waiter queued")
  `CSWT_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, cmd.load_req, !s_axis_tready, "new item taken while a request is open")
  `CSWT_ASSERT_NEXT(a_fetch_then_emit, clk_i, rst_ni, cmd.read_slot, !cmd.read_slot, "two slot fetches in a row")

endmodule
